FILE: src/vmp_pkg.sv
// Shared types and constants of the vector-matrix product core.
package vmp_pkg;

    localparam int IDX_W        = 6;
    localparam int DIM_W        = 7;
    localparam int VAL_W        = 32;
    localparam int ACC_W        = 64;
    localparam int FRAC_W       = 16;
    localparam int MAX_DIM_DEF  = 64;
    localparam int DIM_RESET    = 64;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 40;

    localparam logic [0:0] KIND_VECTOR = 1'b0;
    localparam logic [0:0] KIND_MATRIX = 1'b1;

    localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

    // Control travelling with a matrix entry through the MAC stages
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_row;
        logic             last_col;
        logic [IDX_W-1:0] col;
    } mac_ctl_t;

    // Finished column sum, before saturation
    typedef struct packed {
        logic                    valid;
        logic                    last_col;
        logic [IDX_W-1:0]        col;
        logic signed [ACC_W-1:0] sum;
    } acc_out_t;

    // Result beat as held in the output stage
    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    sat;
        logic                    last;
    } res_t;

endpackage

FILE: src/vector_matrix_product_core.sv
// Top level of the vector-matrix product core.
// Computes b(i) = sum over j of a(j)*T(j,i) in signed Q16.16. Load the vector
// with tuser = 0 beats (row_index = element), then stream matrix entries with
// tuser = 1, column by column, rows ascending. One beat is taken every cycle
// while tready is high; the single-port vector RAM read feeds the multiplier;
// a last-row entry passes the stage-1, product and result registers before
// m_tvalid rises. tready drops only while output and skid stages hold results.
// The dimension register must be written only while the core is idle.
module vector_matrix_product_core
    import vmp_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [DIM_W-1:0]       cfg_wdata,       // dimension
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,         // row_index[5:0], col_index[11:6], value[43:12], zeros
    input  logic                   s_tuser,         // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,         // result_index[5:0], result_value[37:6], zeros
    output logic                   m_tuser,         // saturated
    output logic                   m_tlast
);

    localparam int AW = $clog2(MAX_DIM);

    logic [DIM_W-1:0]        dim_reg;
    logic [DIM_W-1:0]        dim_eff;
    logic [DIM_W-1:0]        last_idx;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    accept;
    logic                    adv;
    logic                    skid_full;
    logic                    vec_wen;
    logic                    in_dim;
    mac_ctl_t                s1_ctl_next;
    mac_ctl_t                s1_ctl_reg;
    logic signed [VAL_W-1:0] s1_value_reg;
    logic signed [VAL_W-1:0] vec_data;
    acc_out_t                acc_res;

    assign row   = s_tdata[IDX_W-1:0];
    assign col   = s_tdata[2*IDX_W-1:IDX_W];
    assign value = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

    assign adv      = !skid_full;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_W'(DIM_RESET);
        end
        else if (cfg_wen)
        begin
            dim_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (dim_reg == '0)
        begin
            dim_eff = DIM_W'(1);
        end
        else if (32'(dim_reg) > 32'(MAX_DIM))
        begin
            dim_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            dim_eff = dim_reg;
        end
        last_idx = dim_eff - DIM_W'(1);
        in_dim   = ({1'b0, row} < dim_eff) && ({1'b0, col} < dim_eff);
        vec_wen  = accept && (s_tuser == KIND_VECTOR) && (32'(row) < 32'(MAX_DIM));

        s1_ctl_next.valid    = accept && (s_tuser == KIND_MATRIX) && in_dim;
        s1_ctl_next.first    = (row == '0);
        s1_ctl_next.last_row = ({1'b0, row} == last_idx);
        s1_ctl_next.last_col = ({1'b0, col} == last_idx);
        s1_ctl_next.col      = col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_value_reg <= value;
        end
    end

    vmp_vector_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .clk   (clk),
        .wen   (vec_wen),
        .ren   (accept && (s_tuser == KIND_MATRIX)),
        .addr  (AW'(row)),
        .wdata (value),
        .rdata (vec_data)
    );

    vmp_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_in   (s1_ctl_reg),
        .value_in (s1_value_reg),
        .vec_data (vec_data),
        .res      (acc_res)
    );

    vmp_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (acc_res),
        .skid_full (skid_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: src/vmp_vector_store.sv
// Vector element store: single-port synchronous RAM with registered read.
module vmp_vector_store
    import vmp_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                    clk,
    input  logic                    wen,
    input  logic                    ren,
    input  logic [$clog2(MAX_DIM)-1:0] addr,
    input  logic signed [VAL_W-1:0] wdata,
    output logic signed [VAL_W-1:0] rdata
);

    logic signed [VAL_W-1:0] mem [MAX_DIM];
    logic signed [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[addr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/vmp_mac.sv
// Multiply stage and column accumulator.
module vmp_mac
    import vmp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  mac_ctl_t                ctl_in,
    input  logic signed [VAL_W-1:0] value_in,
    input  logic signed [VAL_W-1:0] vec_data,
    output acc_out_t                res
);

    mac_ctl_t                s2_ctl_reg;
    logic signed [ACC_W-1:0] product_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    acc_out_t                res_reg;
    acc_out_t                res_next;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] sum;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            product_reg <= ACC_W'(vec_data) * ACC_W'(value_in);
        end
    end

    always_comb
    begin
        // arithmetic shift gives the floor of the Q32.32 product in Q48.16
        term = product_reg >>> FRAC_W;
        sum  = s2_ctl_reg.first ? term : acc_reg + term;
        acc_next = s2_ctl_reg.last_row ? '0 : sum;
        res_next.valid    = s2_ctl_reg.valid && s2_ctl_reg.last_row;
        res_next.last_col = s2_ctl_reg.last_col;
        res_next.col      = s2_ctl_reg.col;
        res_next.sum      = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
            acc_reg    <= '0;
            res_reg    <= '0;
        end
        else if (adv)
        begin
            s2_ctl_reg <= ctl_in;
            res_reg    <= res_next;
            if (s2_ctl_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign res = res_reg;

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s2_ctl_reg.valid && s2_ctl_reg.last_row |=> acc_reg == '0)
        else $error("accumulator not cleared after last row");
    a_emit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s2_ctl_reg.valid && s2_ctl_reg.last_row |=> res_reg.valid)
        else $error("last row gave no result");
`endif

endmodule

FILE: src/vmp_out_buffer.sv
// Saturation to Q16.16 and output register with skid stage.
module vmp_out_buffer
    import vmp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  acc_out_t               res,
    output logic                   skid_full,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // result_index[5:0], result_value[37:6], zeros
    output logic                   m_tuser,   // saturated
    output logic                   m_tlast
);

    res_t out_reg;
    res_t skid_reg;
    res_t new_res;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic pop;
    logic push;
    logic in_range;

    always_comb
    begin
        // sum fits when the top 33 bits are all equal
        in_range = (res.sum[ACC_W-1:VAL_W-1] == '0) || (res.sum[ACC_W-1:VAL_W-1] == '1);
        new_res.index = res.col;
        new_res.last  = res.last_col;
        new_res.sat   = !in_range;
        if (in_range)
        begin
            new_res.value = res.sum[VAL_W-1:0];
        end
        else if (res.sum[ACC_W-1])
        begin
            new_res.value = Q_MIN;
        end
        else
        begin
            new_res.value = Q_MAX;
        end
    end

    assign pop  = out_valid_reg && m_tready;
    assign push = res.valid && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= new_res;
            end
            else
            begin
                out_reg <= new_res;
            end
        end
    end

    assign skid_full = skid_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_TDATA_W - VAL_W - IDX_W){1'b0}}, out_reg.value, out_reg.index};
    assign m_tuser   = out_reg.sat;
    assign m_tlast   = out_reg.last;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.sat |-> (out_reg.value == Q_MAX || out_reg.value == Q_MIN))
        else $error("saturated beat not at a range limit");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for the vector-matrix product core: directed table, then random columns.
`timescale 1ns / 100ps

module tb;
    import vmp_pkg::*;

    typedef enum logic {DO_BEAT, DO_DIM} step_t;

    typedef struct {
        step_t       what;
        logic [0:0]  kind;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] val;
        bit          typed;
        logic [5:0]  w_idx;
        logic [31:0] w_val;
        logic        w_sat;
        logic        w_last;
    } plan_row_t;

    localparam int PLAN_LEN     = 27;
    localparam int RANDOM_BEATS = 1150;
    localparam int IDLE_PCT     = 23;
    localparam int SETTLE       = 12;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [DIM_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;          // row_index[5:0], col_index[11:6], value[43:12]
    logic                   s_tuser = 1'b0;        // kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;               // result_index[5:0], result_value[37:6]
    logic                   m_tuser;               // saturated
    logic                   m_tlast;

    // predictor state
    logic [31:0]    vec_mirror [64];
    longint         acc_mirror = 0;
    logic [6:0]     dim_mirror = 7'd64;

    res_t           due_results [$];
    res_t           head;
    int             mismatches = 0;
    int             beats_used = 0;
    bit             no_gaps = 1'b0;

    plan_row_t plan [PLAN_LEN] = '{
        // accumulator is clear out of reset, so a lone last-row entry emits its own term
        '{DO_BEAT, KIND_VECTOR, 6'd63, 6'd0,  32'h0001_0000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd63, 6'd63, 32'h0003_0000, 1'b1, 6'd63, 32'h0003_0000, 1'b0, 1'b1},
        '{DO_DIM,  KIND_VECTOR, 6'd0,  6'd0,  32'd2,         1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_VECTOR, 6'd0,  6'd0,  32'h7fff_ffff, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_VECTOR, 6'd1,  6'd0,  32'h8000_0000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd0,  6'd0,  32'h7fff_ffff, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd1,  6'd0,  32'h8000_0000, 1'b1, 6'd0,  32'h7fff_ffff, 1'b1, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd0,  6'd1,  32'h8000_0000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd1,  6'd1,  32'h7fff_ffff, 1'b1, 6'd1,  32'h8000_0000, 1'b1, 1'b1},
        // row and column beyond the dimension: dropped
        '{DO_BEAT, KIND_MATRIX, 6'd5,  6'd0,  32'h1234_5678, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd0,  6'd63, 32'h1234_5678, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        // zero dimension behaves as one
        '{DO_DIM,  KIND_VECTOR, 6'd0,  6'd0,  32'd0,         1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_VECTOR, 6'd0,  6'd0,  32'hffff_ffff, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        // -1 ulp times +1 ulp rounds down to -1 ulp
        '{DO_BEAT, KIND_MATRIX, 6'd0,  6'd0,  32'h0000_0001, 1'b1, 6'd0,  32'hffff_ffff, 1'b0, 1'b1},
        '{DO_BEAT, KIND_MATRIX, 6'd0,  6'd1,  32'h0000_ffff, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        // oversized dimension clamps to 64
        '{DO_DIM,  KIND_VECTOR, 6'd0,  6'd0,  32'd127,       1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd63, 6'd5,  32'hffff_0000, 1'b1, 6'd5,  32'hffff_0000, 1'b0, 1'b0},
        '{DO_DIM,  KIND_VECTOR, 6'd0,  6'd0,  32'd3,         1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_VECTOR, 6'd0,  6'd0,  32'h0002_0000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_VECTOR, 6'd1,  6'd0,  32'h0000_8000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_VECTOR, 6'd2,  6'd0,  32'hffff_0000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        // stray row before row 0, which must overwrite it
        '{DO_BEAT, KIND_MATRIX, 6'd1,  6'd0,  32'h7fff_0000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd0,  6'd0,  32'h0001_0000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd2,  6'd0,  32'h0001_0000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd0,  6'd2,  32'h0001_0000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd1,  6'd2,  32'h0004_0000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0},
        '{DO_BEAT, KIND_MATRIX, 6'd2,  6'd2,  32'h0002_0000, 1'b0, 6'd0,  32'h0, 1'b0, 1'b0}
    };

    vector_matrix_product_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic int unsigned eff_dim(input logic [6:0] d);
        if (d == 7'd0)
            return 1;
        if (d > 7'd64)
            return 64;
        return 32'(d);
    endfunction

    // One multiply-accumulate step; returns 1 when a column sum is due
    function automatic bit gemv_step(input logic [0:0] kind, input logic [5:0] row,
                                     input logic [5:0] col, input logic [31:0] val,
                                     output res_t res);
        int unsigned n;
        longint      term;
        n   = eff_dim(dim_mirror);
        res = '0;
        if (kind == KIND_VECTOR)
        begin
            vec_mirror[row] = val;
            return 1'b0;
        end
        if (row >= n || col >= n)
            return 1'b0;
        // arithmetic shift floors the Q32.32 product to Q48.16
        term = (longint'($signed(vec_mirror[row])) * longint'($signed(val))) >>> FRAC_W;
        if (row == 6'd0)
            acc_mirror = term;
        else
            acc_mirror = acc_mirror + term;
        if (row != n - 1)
            return 1'b0;
        res.index = col;
        res.last  = (col == n - 1);
        if (acc_mirror > longint'(Q_MAX))
        begin
            res.value = Q_MAX;
            res.sat   = 1'b1;
        end
        else if (acc_mirror < longint'(Q_MIN))
        begin
            res.value = Q_MIN;
            res.sat   = 1'b1;
        end
        else
            res.value = 32'(acc_mirror);
        acc_mirror = 0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom();
        endcase
    endfunction

    // s_tvalid is left high after the beat; callers that pause lower it themselves
    task automatic send_beat(input logic [0:0] kind, input logic [5:0] row, input logic [5:0] col,
                             input logic [31:0] val, input bit typed, input res_t want);
        res_t got;
        if (!no_gaps)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, val, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == KIND_VECTOR || (row < eff_dim(dim_mirror) && col < eff_dim(dim_mirror)))
            beats_used++;
        if (gemv_step(kind, row, col, val, got))
            due_results.push_back(typed ? want : got);
    endtask

    task automatic set_dimension(input logic [6:0] d);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        // dropped beats leave nothing to wait on, so give the pipeline time to drain
        repeat (SETTLE) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_wen    <= 1'b0;
        dim_mirror = d;
    endtask

    task automatic send_noise(input int unsigned n);
        case ($urandom_range(0, 2))
            0: send_beat(KIND_VECTOR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                         rand_q16(), 1'b0, '0);
            1: send_beat(KIND_MATRIX, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                         rand_q16(), 1'b0, '0);
            default: send_beat(KIND_MATRIX,
                               6'((n < 64) ? $urandom_range(n, 63) : $urandom_range(0, 63)),
                               6'($urandom_range(0, 63)), rand_q16(), 1'b0, '0);
        endcase
    endtask

    task automatic run_columns(input logic [6:0] d);
        int unsigned n;
        int unsigned ncols;
        int unsigned first;
        set_dimension(d);
        n     = eff_dim(d);
        ncols = (n <= 4) ? n : $urandom_range(1, (n > 16) ? 2 : 4);
        first = ($urandom_range(0, 2) == 0) ? n - ncols : $urandom_range(0, n - ncols);
        for (int unsigned c = first; c < first + ncols; c++)
        begin
            for (int unsigned r = 0; r < n; r++)
            begin
                if ($urandom_range(0, 99) < 8)
                    send_noise(n);
                // now and then a column is cut short
                if (r > 0 && $urandom_range(0, 99) < 2)
                    break;
                send_beat(KIND_MATRIX, 6'(r), 6'(c), rand_q16(), 1'b0, '0);
            end
        end
    endtask

    // result side: check on each accepted beat, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_results.size() == 0)
            begin
                $error("result beat with nothing pending: index %0d value %h",
                       m_tdata[5:0], m_tdata[37:6]);
                mismatches++;
            end
            else
            begin
                head = due_results.pop_front();
                if (m_tdata[5:0] !== head.index)
                begin
                    $error("result_index: expected %0d, got %0d", head.index, m_tdata[5:0]);
                    mismatches++;
                end
                if (m_tdata[37:6] !== head.value)
                begin
                    $error("result_value: expected %h, got %h", head.value, m_tdata[37:6]);
                    mismatches++;
                end
                if (m_tuser !== head.sat)
                begin
                    $error("saturated: expected %0b, got %0b", head.sat, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== head.last)
                begin
                    $error("last: expected %0b, got %0b", head.last, m_tlast);
                    mismatches++;
                end
            end
        end
        m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        int         target;
        int         phase;
        logic [6:0] d;
        res_t       want;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < PLAN_LEN; k++)
        begin
            if (plan[k].what == DO_DIM)
                set_dimension(plan[k].val[6:0]);
            else
            begin
                want = '{index: plan[k].w_idx, value: plan[k].w_val,
                         sat: plan[k].w_sat, last: plan[k].w_last};
                send_beat(plan[k].kind, plan[k].row, plan[k].col, plan[k].val,
                          plan[k].typed, want);
            end
        end

        // every vector element is written before random columns may read it
        for (int j = 0; j < 64; j++)
            send_beat(KIND_VECTOR, 6'(j), 6'($urandom_range(0, 63)), rand_q16(), 1'b0, '0);

        target = beats_used + RANDOM_BEATS;
        phase  = 0;
        while (beats_used < target)
        begin
            case (phase)
                0:       d = 7'd64;
                1:       d = 7'd1;
                2:       d = 7'd0;
                3:       d = 7'd127;
                4:       d = 7'd2;
                default:
                    case ($urandom_range(0, 9))
                        0:       d = 7'd64;
                        1:       d = 7'($urandom_range(9, 63));
                        2:       d = 7'($urandom_range(65, 127));
                        default: d = 7'($urandom_range(1, 8));
                    endcase
            endcase
            // a long run with neither side idling
            no_gaps <= (beats_used >= target - RANDOM_BEATS + 450) &&
                       (beats_used <  target - RANDOM_BEATS + 800);
            run_columns(d);
            phase++;
        end

        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
src/vmp_pkg.sv
src/vmp_vector_store.sv
src/vmp_mac.sv
src/vmp_out_buffer.sv
src/vector_matrix_product_core.sv
tb/sv/tb.sv
